FILE: rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the environmental sensor compensation core.
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam int RawTempWidth  = 20;
   localparam int RawPressWidth = 20;
   localparam int RawHumWidth   = 16;
   localparam int WordWidth     = 32;
   localparam int HumOutWidth   = 17;
   localparam int CsrDataWidth  = 64;
   localparam int CsrIndexWidth = 3;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TEMP_TRIM    = 3'd0,
      CSR_PRESS_TRIM_A = 3'd1,
      CSR_PRESS_TRIM_B = 3'd2,
      CSR_PRESS_TRIM_C = 3'd3,
      CSR_HUM_TRIM     = 3'd4
   } csr_index_type;

   localparam logic signed [31:0] PressOffset  = 32'sd64000;
   localparam logic signed [31:0] PressFull    = 32'sd1048576;
   localparam logic signed [31:0] PressScale   = 32'sd3125;
   localparam logic signed [31:0] HumOffset    = 32'sd76800;
   localparam logic signed [31:0] HumLimit     = 32'sd419430400;
   localparam logic signed [31:0] HumBias      = 32'sd2097152;
   localparam logic signed [31:0] RoundH14     = 32'sd16384;
   localparam logic signed [31:0] Half15       = 32'sd32768;
   localparam logic signed [31:0] RoundH13     = 32'sd8192;
   localparam logic signed [31:0] RoundT8      = 32'sd128;
   localparam logic signed [31:0] TempMul      = 32'sd5;

   // Trim coefficients, each widened to a full 32-bit word.
   typedef struct packed {
      logic signed [31:0] t1;
      logic signed [31:0] t2;
      logic signed [31:0] t3;
      logic signed [31:0] p1;
      logic signed [31:0] p2;
      logic signed [31:0] p3;
      logic signed [31:0] p4;
      logic signed [31:0] p5;
      logic signed [31:0] p6;
      logic signed [31:0] p7;
      logic signed [31:0] p8;
      logic signed [31:0] p9;
      logic signed [31:0] h1;
      logic signed [31:0] h2;
      logic signed [31:0] h3;
      logic signed [31:0] h4;
      logic signed [31:0] h5;
      logic signed [31:0] h6;
   } trim_type;

   // Finished fields that ride along with the pressure word.
   typedef struct packed {
      logic                   valid;
      logic signed [31:0]     temp;
      logic signed [31:0]     fine;
      logic [HumOutWidth-1:0] hum;
   } side_type;

   typedef struct packed {
      side_type    side;
      logic        big;
      logic [31:0] dvd;
      logic [31:0] dvs;
   } div_word_type;

   typedef struct packed {
      side_type    side;
      logic        big;
      logic        zero;
      logic [31:0] quo;
   } quo_word_type;

endpackage

FILE: rtl/env_sensor_compensation_core.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation_core
// Integer compensation of raw temperature, pressure and humidity samples.
// ----------------------------------------------------------------------------
// The req channel carries one raw sample word; the rsp channel returns one
// word with temperature, pressure, humidity and fine temperature. A word is
// moved when valid is high and stall is low. The csr port writes the trim
// registers (temperature, three pressure groups, humidity) by index; the user
// must write them only while no sample is in flight; the core does not
// enforce this. From acceptance to rsp_valid, 13 stages compute the fine
// temperature, humidity and divide operands, 32 stages form the pressure
// quotient one bit each, and 4 stages finish pressure and hold the result.
// Throughput is one word per cycle unless the receiver stalls: then, with a
// word waiting, the whole pipeline holds, req_stall is raised and nothing is
// dropped or repeated. Reset clears all valid bits and the trim registers.
// ----------------------------------------------------------------------------
module env_sensor_compensation_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [esc_pkg::RawTempWidth-1:0]       req_raw_temperature,
   input  logic [esc_pkg::RawPressWidth-1:0]      req_raw_pressure,
   input  logic [esc_pkg::RawHumWidth-1:0]        req_raw_humidity,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [31:0]                     rsp_temperature_centi,
   output logic [31:0]                            rsp_pressure_pascal,
   output logic [esc_pkg::HumOutWidth-1:0]        rsp_humidity_q10,
   output logic signed [31:0]                     rsp_fine_temperature,
   input  logic                                   csr_write,
   input  logic [esc_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [esc_pkg::CsrDataWidth-1:0]       csr_wdata
);

   logic [47:0] temp_trim_ff, press_a_ff, press_b_ff, press_c_ff;
   logic [63:0] hum_trim_ff;
   logic        en;

   esc_pkg::trim_type     trim;
   esc_pkg::div_word_type div_word;
   esc_pkg::quo_word_type quo_word;
   esc_pkg::side_type     out_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff <= '0;
         press_a_ff   <= '0;
         press_b_ff   <= '0;
         press_c_ff   <= '0;
         hum_trim_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            esc_pkg::CSR_TEMP_TRIM:    temp_trim_ff <= csr_wdata[47:0];
            esc_pkg::CSR_PRESS_TRIM_A: press_a_ff   <= csr_wdata[47:0];
            esc_pkg::CSR_PRESS_TRIM_B: press_b_ff   <= csr_wdata[47:0];
            esc_pkg::CSR_PRESS_TRIM_C: press_c_ff   <= csr_wdata[47:0];
            esc_pkg::CSR_HUM_TRIM:     hum_trim_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign trim.t1 = $signed({16'd0, temp_trim_ff[15:0]});
   assign trim.t2 = 32'($signed(temp_trim_ff[31:16]));
   assign trim.t3 = 32'($signed(temp_trim_ff[47:32]));
   assign trim.p1 = $signed({16'd0, press_a_ff[15:0]});
   assign trim.p2 = 32'($signed(press_a_ff[31:16]));
   assign trim.p3 = 32'($signed(press_a_ff[47:32]));
   assign trim.p4 = 32'($signed(press_b_ff[15:0]));
   assign trim.p5 = 32'($signed(press_b_ff[31:16]));
   assign trim.p6 = 32'($signed(press_b_ff[47:32]));
   assign trim.p7 = 32'($signed(press_c_ff[15:0]));
   assign trim.p8 = 32'($signed(press_c_ff[31:16]));
   assign trim.p9 = 32'($signed(press_c_ff[47:32]));
   assign trim.h1 = $signed({24'd0, hum_trim_ff[7:0]});
   assign trim.h2 = 32'($signed(hum_trim_ff[23:8]));
   assign trim.h3 = $signed({24'd0, hum_trim_ff[31:24]});
   assign trim.h4 = 32'($signed(hum_trim_ff[43:32]));
   assign trim.h5 = 32'($signed(hum_trim_ff[55:44]));
   assign trim.h6 = 32'($signed(hum_trim_ff[63:56]));

   assign en        = !(out_side.valid && rsp_stall);
   assign req_stall = !en;

   esc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .trim     (trim),
      .in_valid (req_valid),
      .raw_t    (req_raw_temperature),
      .raw_p    (req_raw_pressure),
      .raw_h    (req_raw_humidity),
      .out_word (div_word)
   );

   esc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_word  (div_word),
      .out_word (quo_word)
   );

   esc_press_post u_post (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .trim      (trim),
      .in_word   (quo_word),
      .out_side  (out_side),
      .out_press (rsp_pressure_pascal)
   );

   assign rsp_valid             = out_side.valid;
   assign rsp_temperature_centi = out_side.temp;
   assign rsp_humidity_q10      = out_side.hum;
   assign rsp_fine_temperature  = out_side.fine;

endmodule

FILE: rtl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Fine temperature, temperature, humidity and the pressure divide operands.
// ----------------------------------------------------------------------------
module esc_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  esc_pkg::trim_type                     trim,
   input  logic                                  in_valid,
   input  logic [esc_pkg::RawTempWidth-1:0]      raw_t,
   input  logic [esc_pkg::RawPressWidth-1:0]     raw_p,
   input  logic [esc_pkg::RawHumWidth-1:0]       raw_h,
   output esc_pkg::div_word_type                 out_word
);

   logic signed [31:0] at_w, ap_w, ah_w, x1_w, d_w;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   logic v11_ff, v12_ff, v13_ff;
   logic signed [31:0] rp1_ff, rp2_ff, rp3_ff, rp4_ff, rp5_ff, rp6_ff, rp7_ff;
   logic signed [31:0] rh1_ff, rh2_ff, rh3_ff, rh4_ff, rh5_ff;
   logic signed [31:0] m1_ff, m2_ff, a2_ff, m3_ff;
   logic signed [31:0] fine3_ff, fine4_ff, fine5_ff, fine6_ff, fine7_ff, fine8_ff;
   logic signed [31:0] fine9_ff, fine10_ff, fine11_ff, fine12_ff, fine13_ff;
   logic signed [31:0] tm4_ff, pa4_ff, ha4_ff;
   logic signed [31:0] temp5_ff, temp6_ff, temp7_ff, temp8_ff, temp9_ff, temp10_ff;
   logic signed [31:0] temp11_ff, temp12_ff, temp13_ff;
   logic signed [31:0] q5_ff, ap5_5_ff, ap2_5_ff, h5m5_ff, h6m5_ff, h3m5_ff;
   logic signed [31:0] bq6_ff, p3m6_ff, ap5_6_ff, ap2_6_ff, hb6_ff, m7_6_ff;
   logic signed [31:0] b7_ff, a7_ff, hb7_ff, d7_ff;
   logic signed [31:0] p1m8_ff, nd8_ff, hb8_ff, hd8_ff;
   logic signed [31:0] div9_ff, num9_ff, hb9_ff, d2_9_ff;
   logic signed [31:0] div10_ff, num10_ff, hx10_ff;
   logic signed [31:0] sq11_ff, hx11_ff, hm12_ff, hx12_ff;
   logic [31:0]        dvd11_ff, dvs11_ff, dvd12_ff, dvs12_ff, dvd13_ff, dvs13_ff;
   logic               big11_ff, big12_ff, big13_ff;
   logic [esc_pkg::HumOutWidth-1:0] hum13_ff;
   logic signed [31:0] hfin_w;

   assign at_w = $signed({12'd0, raw_t});
   assign ap_w = $signed({12'd0, raw_p});
   assign ah_w = $signed({16'd0, raw_h});
   assign x1_w = (at_w >>> 3) - (trim.t1 <<< 1);
   assign d_w  = (at_w >>> 4) - trim.t1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
         v6_ff <= 1'b0; v7_ff <= 1'b0; v8_ff <= 1'b0; v9_ff <= 1'b0; v10_ff <= 1'b0;
         v11_ff <= 1'b0; v12_ff <= 1'b0; v13_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff; v7_ff <= v6_ff; v8_ff <= v7_ff;
         v9_ff <= v8_ff; v10_ff <= v9_ff; v11_ff <= v10_ff; v12_ff <= v11_ff;
         v13_ff <= v12_ff;
      end
   end

   assign hfin_w = hx12_ff - ((hm12_ff >>> 4));

   always_ff @(posedge clock) begin
      if (en) begin
         // Stage 1: temperature products.
         rp1_ff <= ap_w;
         rh1_ff <= ah_w;
         m1_ff  <= x1_w * trim.t2;
         m2_ff  <= d_w * d_w;
         // Stage 2.
         rp2_ff <= rp1_ff;
         rh2_ff <= rh1_ff;
         a2_ff  <= m1_ff >>> 11;
         m3_ff  <= (m2_ff >>> 12) * trim.t3;
         // Stage 3: fine temperature.
         rp3_ff   <= rp2_ff;
         rh3_ff   <= rh2_ff;
         fine3_ff <= a2_ff + (m3_ff >>> 14);
         // Stage 4.
         rp4_ff   <= rp3_ff;
         rh4_ff   <= rh3_ff;
         fine4_ff <= fine3_ff;
         tm4_ff   <= fine3_ff * esc_pkg::TempMul;
         pa4_ff   <= (fine3_ff >>> 1) - esc_pkg::PressOffset;
         ha4_ff   <= fine3_ff - esc_pkg::HumOffset;
         // Stage 5.
         rp5_ff   <= rp4_ff;
         rh5_ff   <= rh4_ff;
         fine5_ff <= fine4_ff;
         temp5_ff <= (tm4_ff + esc_pkg::RoundT8) >>> 8;
         q5_ff    <= (pa4_ff >>> 2) * (pa4_ff >>> 2);
         ap5_5_ff <= pa4_ff * trim.p5;
         ap2_5_ff <= trim.p2 * pa4_ff;
         h5m5_ff  <= trim.h5 * ha4_ff;
         h6m5_ff  <= ha4_ff * trim.h6;
         h3m5_ff  <= ha4_ff * trim.h3;
         // Stage 6.
         rp6_ff   <= rp5_ff;
         fine6_ff <= fine5_ff;
         temp6_ff <= temp5_ff;
         bq6_ff   <= (q5_ff >>> 11) * trim.p6;
         p3m6_ff  <= trim.p3 * (q5_ff >>> 13);
         ap5_6_ff <= ap5_5_ff;
         ap2_6_ff <= ap2_5_ff;
         hb6_ff   <= (((rh5_ff <<< 14) - (trim.h4 <<< 20) - h5m5_ff) + esc_pkg::RoundH14)
                     >>> 15;
         m7_6_ff  <= (h6m5_ff >>> 10) * ((h3m5_ff >>> 11) + esc_pkg::Half15);
         // Stage 7.
         rp7_ff   <= rp6_ff;
         fine7_ff <= fine6_ff;
         temp7_ff <= temp6_ff;
         b7_ff    <= ((bq6_ff + (ap5_6_ff <<< 1)) >>> 2) + (trim.p4 <<< 16);
         a7_ff    <= ((p3m6_ff >>> 3) + (ap2_6_ff >>> 1)) >>> 18;
         hb7_ff   <= hb6_ff;
         d7_ff    <= (m7_6_ff >>> 10) + esc_pkg::HumBias;
         // Stage 8.
         fine8_ff <= fine7_ff;
         temp8_ff <= temp7_ff;
         p1m8_ff  <= (esc_pkg::Half15 + a7_ff) * trim.p1;
         nd8_ff   <= (esc_pkg::PressFull - rp7_ff) - (b7_ff >>> 12);
         hb8_ff   <= hb7_ff;
         hd8_ff   <= d7_ff * trim.h2;
         // Stage 9.
         fine9_ff <= fine8_ff;
         temp9_ff <= temp8_ff;
         div9_ff  <= p1m8_ff >>> 15;
         num9_ff  <= nd8_ff * esc_pkg::PressScale;
         hb9_ff   <= hb8_ff;
         d2_9_ff  <= (hd8_ff + esc_pkg::RoundH13) >>> 14;
         // Stage 10.
         fine10_ff <= fine9_ff;
         temp10_ff <= temp9_ff;
         div10_ff  <= div9_ff;
         num10_ff  <= num9_ff;
         hx10_ff   <= hb9_ff * d2_9_ff;
         // Stage 11: the dividend is doubled before the divide unless it is large.
         fine11_ff <= fine10_ff;
         temp11_ff <= temp10_ff;
         big11_ff  <= num10_ff[31];
         dvd11_ff  <= num10_ff[31] ? $unsigned(num10_ff) : $unsigned(num10_ff <<< 1);
         dvs11_ff  <= $unsigned(div10_ff);
         sq11_ff   <= (hx10_ff >>> 15) * (hx10_ff >>> 15);
         hx11_ff   <= hx10_ff;
         // Stage 12.
         fine12_ff <= fine11_ff;
         temp12_ff <= temp11_ff;
         big12_ff  <= big11_ff;
         dvd12_ff  <= dvd11_ff;
         dvs12_ff  <= dvs11_ff;
         hm12_ff   <= (sq11_ff >>> 7) * trim.h1;
         hx12_ff   <= hx11_ff;
         // Stage 13: humidity clamp and final shift.
         fine13_ff <= fine12_ff;
         temp13_ff <= temp12_ff;
         big13_ff  <= big12_ff;
         dvd13_ff  <= dvd12_ff;
         dvs13_ff  <= dvs12_ff;
         if (hfin_w < 0) begin
            hum13_ff <= '0;
         end else if (hfin_w > esc_pkg::HumLimit) begin
            hum13_ff <= esc_pkg::HumLimit[28:12];
         end else begin
            hum13_ff <= hfin_w[28:12];
         end
      end
   end

   assign out_word.side.valid = v13_ff;
   assign out_word.side.temp  = temp13_ff;
   assign out_word.side.fine  = fine13_ff;
   assign out_word.side.hum   = hum13_ff;
   assign out_word.big        = big13_ff;
   assign out_word.dvd        = dvd13_ff;
   assign out_word.dvs        = dvs13_ff;

endmodule

FILE: rtl/esc_divider.sv
// ----------------------------------------------------------------------------
// esc_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module esc_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  esc_pkg::div_word_type in_word,
   output esc_pkg::quo_word_type out_word
);

   localparam int Bits = esc_pkg::WordWidth;

   esc_pkg::side_type side_ff [Bits];
   logic              big_ff  [Bits];
   logic [Bits-1:0]   rem_ff  [Bits];
   logic [Bits-1:0]   dvd_ff  [Bits];
   logic [Bits-1:0]   dvs_ff  [Bits];
   logic [Bits-1:0]   quo_ff  [Bits];

   for (genvar k = 0; k < Bits; k++) begin : g_stage
      esc_pkg::side_type side_src;
      logic              big_src;
      logic [Bits-1:0]   rem_src, dvd_src, dvs_src, quo_src;
      logic [Bits:0]     trial;
      logic              fits;

      if (k == 0) begin : g_first
         assign side_src = in_word.side;
         assign big_src  = in_word.big;
         assign rem_src  = '0;
         assign dvd_src  = in_word.dvd;
         assign dvs_src  = in_word.dvs;
         assign quo_src  = '0;
      end else begin : g_next
         assign side_src = side_ff[k-1];
         assign big_src  = big_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign dvd_src  = dvd_ff[k-1];
         assign dvs_src  = dvs_ff[k-1];
         assign quo_src  = quo_ff[k-1];
      end

      assign trial = {rem_src, dvd_src[Bits-1]};
      assign fits  = trial >= {1'b0, dvs_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k].valid <= 1'b0;
         end else if (en) begin
            side_ff[k].valid <= side_src.valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k].temp <= side_src.temp;
            side_ff[k].fine <= side_src.fine;
            side_ff[k].hum  <= side_src.hum;
            big_ff[k]       <= big_src;
            dvd_ff[k]       <= {dvd_src[Bits-2:0], 1'b0};
            dvs_ff[k]       <= dvs_src;
            quo_ff[k]       <= {quo_src[Bits-2:0], fits};
            rem_ff[k]       <= fits ? Bits'(trial - {1'b0, dvs_src}) : trial[Bits-1:0];
         end
      end
   end

   assign out_word.side = side_ff[Bits-1];
   assign out_word.big  = big_ff[Bits-1];
   assign out_word.zero = (dvs_ff[Bits-1] == '0);
   assign out_word.quo  = quo_ff[Bits-1];

endmodule

FILE: rtl/esc_press_post.sv
// ----------------------------------------------------------------------------
// esc_press_post
// Pressure correction after the divide; its last stage is the output word.
// ----------------------------------------------------------------------------
module esc_press_post (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  esc_pkg::trim_type     trim,
   input  esc_pkg::quo_word_type in_word,
   output esc_pkg::side_type     out_side,
   output logic [31:0]           out_press
);

   esc_pkg::side_type side1_ff, side2_ff, side3_ff, side4_ff;
   logic              zero1_ff, zero2_ff, zero3_ff;
   logic [31:0]       p1_ff, p2_ff, p3_ff, msq2_ff, press4_ff;
   logic signed [31:0] m8_2_ff, m8_3_ff, m9_3_ff, corr_w;
   logic [31:0]       sh_w;

   assign sh_w   = p1_ff >> 3;
   assign corr_w = ((m9_3_ff >>> 12) + (m8_3_ff >>> 13) + trim.p7) >>> 4;

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff.valid <= 1'b0;
         side2_ff.valid <= 1'b0;
         side3_ff.valid <= 1'b0;
         side4_ff.valid <= 1'b0;
      end else if (en) begin
         side1_ff.valid <= in_word.side.valid;
         side2_ff.valid <= side1_ff.valid;
         side3_ff.valid <= side2_ff.valid;
         side4_ff.valid <= side3_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff.temp <= in_word.side.temp;
         side1_ff.fine <= in_word.side.fine;
         side1_ff.hum  <= in_word.side.hum;
         zero1_ff      <= in_word.zero;
         p1_ff         <= in_word.big ? {in_word.quo[30:0], 1'b0} : in_word.quo;
         side2_ff.temp <= side1_ff.temp;
         side2_ff.fine <= side1_ff.fine;
         side2_ff.hum  <= side1_ff.hum;
         zero2_ff      <= zero1_ff;
         p2_ff         <= p1_ff;
         msq2_ff       <= sh_w * sh_w;
         m8_2_ff       <= $signed(p1_ff >> 2) * trim.p8;
         side3_ff.temp <= side2_ff.temp;
         side3_ff.fine <= side2_ff.fine;
         side3_ff.hum  <= side2_ff.hum;
         zero3_ff      <= zero2_ff;
         p3_ff         <= p2_ff;
         m8_3_ff       <= m8_2_ff;
         m9_3_ff       <= trim.p9 * $signed(msq2_ff >> 13);
         side4_ff.temp <= side3_ff.temp;
         side4_ff.fine <= side3_ff.fine;
         side4_ff.hum  <= side3_ff.hum;
         press4_ff     <= zero3_ff ? '0 : p3_ff + $unsigned(corr_w);
      end
   end

   assign out_side  = side4_ff;
   assign out_press = press4_ff;

endmodule

FILE: tb/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker
// Predicts and checks every compensated word of the compensation core.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the trim registers and captures csr
// writes as they happen. For each accepted sample word it computes the
// expected temperature, pressure, humidity and fine temperature in 32-bit
// wrapping arithmetic. It then compares each accepted result word, as a whole,
// with the oldest expected word.
// ----------------------------------------------------------------------------
module esc_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [esc_pkg::RawTempWidth-1:0]  req_raw_temperature,
   input  logic [esc_pkg::RawPressWidth-1:0] req_raw_pressure,
   input  logic [esc_pkg::RawHumWidth-1:0]   req_raw_humidity,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [31:0]                rsp_temperature_centi,
   input  logic [31:0]                       rsp_pressure_pascal,
   input  logic [esc_pkg::HumOutWidth-1:0]   rsp_humidity_q10,
   input  logic signed [31:0]                rsp_fine_temperature,
   input  logic                              csr_write,
   input  logic [esc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [esc_pkg::CsrDataWidth-1:0]  csr_wdata,
   output int                                error_count,
   output int                                pending_count,
   output int                                checked_count
);

   typedef struct packed {
      logic [31:0]                     temp;
      logic [31:0]                     press;
      logic [esc_pkg::HumOutWidth-1:0] hum;
      logic [31:0]                     fine;
   } reading_type;

   logic [47:0] temp_trim, press_a, press_b, press_c;
   logic [63:0] hum_trim;
   reading_type expected_readings[$];

   function automatic logic [31:0] asr(logic [31:0] x, int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic reading_type compensate(logic [19:0] rt, logic [19:0] rp,
                                              logic [15:0] rh);
      logic [31:0] at, ap, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6, a, b, d, p, q, fine;
      reading_type r;
      at = {12'd0, rt};
      ap = {12'd0, rp};
      ah = {16'd0, rh};
      t1 = {16'd0, temp_trim[15:0]};
      t2 = sx16(temp_trim[31:16]);
      t3 = sx16(temp_trim[47:32]);
      p1 = {16'd0, press_a[15:0]};
      p2 = sx16(press_a[31:16]);
      p3 = sx16(press_a[47:32]);
      p4 = sx16(press_b[15:0]);
      p5 = sx16(press_b[31:16]);
      p6 = sx16(press_b[47:32]);
      p7 = sx16(press_c[15:0]);
      p8 = sx16(press_c[31:16]);
      p9 = sx16(press_c[47:32]);
      h1 = {24'd0, hum_trim[7:0]};
      h2 = sx16(hum_trim[23:8]);
      h3 = {24'd0, hum_trim[31:24]};
      h4 = {{20{hum_trim[43]}}, hum_trim[43:32]};
      h5 = {{20{hum_trim[55]}}, hum_trim[55:44]};
      h6 = {{24{hum_trim[63]}}, hum_trim[63:56]};

      a = asr(((at >> 3) - (t1 << 1)) * t2, 11);
      d = (at >> 4) - t1;
      b = asr(asr(d * d, 12) * t3, 14);
      fine = a + b;
      r.temp = asr(fine * 32'd5 + 32'd128, 8);

      a = asr(fine, 1) - 32'd64000;
      q = asr(a, 2) * asr(a, 2);
      b = asr(q, 11) * p6;
      b = b + ((a * p5) << 1);
      b = asr(b, 2) + (p4 << 16);
      a = asr(asr(p3 * asr(q, 13), 3) + asr(p2 * a, 1), 18);
      a = asr((32'd32768 + a) * p1, 15);
      if (a == 32'd0) begin
         p = 32'd0;
      end else begin
         p = ((32'd1048576 - ap) - asr(b, 12)) * 32'd3125;
         if (p < 32'h8000_0000) begin
            p = (p << 1) / a;
         end else begin
            p = (p / a) * 32'd2;
         end
         a = asr(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
         b = asr((p >> 2) * p8, 13);
         p = p + asr(a + b + p7, 4);
      end
      r.press = p;

      a = fine - 32'd76800;
      b = asr(((ah << 14) - (h4 << 20) - (h5 * a)) + 32'd16384, 15);
      d = asr(asr(asr(a * h6, 10) * (asr(a * h3, 11) + 32'd32768), 10) + 32'd2097152, 0);
      d = asr(d * h2 + 32'd8192, 14);
      a = b * d;
      a = a - asr(asr(asr(a, 15) * asr(a, 15), 7) * h1, 4);
      if (a[31]) begin
         a = 32'd0;
      end
      if (a > 32'd419430400) begin
         a = 32'd419430400;
      end
      r.hum = a[28:12];
      r.fine = fine;
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type got, want;
      if (reset) begin
         temp_trim <= '0;
         press_a <= '0;
         press_b <= '0;
         press_c <= '0;
         hum_trim <= '0;
         expected_readings.delete();
         error_count <= 0;
         pending_count <= 0;
         checked_count <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               esc_pkg::CSR_TEMP_TRIM: begin
                  temp_trim <= csr_wdata[47:0];
               end
               esc_pkg::CSR_PRESS_TRIM_A: begin
                  press_a <= csr_wdata[47:0];
               end
               esc_pkg::CSR_PRESS_TRIM_B: begin
                  press_b <= csr_wdata[47:0];
               end
               esc_pkg::CSR_PRESS_TRIM_C: begin
                  press_c <= csr_wdata[47:0];
               end
               esc_pkg::CSR_HUM_TRIM: begin
                  hum_trim <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_readings.push_back(compensate(req_raw_temperature, req_raw_pressure,
                                                   req_raw_humidity));
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_temperature_centi, rsp_pressure_pascal, rsp_humidity_q10,
                   rsp_fine_temperature};
            if (expected_readings.size() == 0) begin
               if (error_count < 10) begin
                  $display("ERROR: unexpected result word %h", got);
               end
               error_count <= error_count + 1;
            end else begin
               want = expected_readings.pop_front();
               if (got !== want) begin
                  if (error_count < 10) begin
                     $display("ERROR: exp t=%0d p=%0d h=%0d f=%0d got t=%0d p=%0d h=%0d f=%0d",
                              $signed(want.temp), want.press, want.hum, $signed(want.fine),
                              $signed(got.temp), got.press, got.hum, $signed(got.fine));
                  end
                  error_count <= error_count + 1;
               end
            end
            checked_count <= checked_count + 1;
         end
         pending_count <= expected_readings.size();
      end
   end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the environmental sensor compensation core.
// ----------------------------------------------------------------------------
// The core starts on all-zero reset trims; further settings, including all
// ones and typical sensor factory values, are loaded while it is idle. Each
// loaded one gets directed corner samples, then random samples in bursts
// as the receiver stalls on its own pattern. The checker predicts every word.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int Latency = 49;
   localparam int CycleLimit = 400000;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [esc_pkg::RawTempWidth-1:0]  req_raw_temperature;
   logic [esc_pkg::RawPressWidth-1:0] req_raw_pressure;
   logic [esc_pkg::RawHumWidth-1:0]   req_raw_humidity;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic signed [31:0]                rsp_temperature_centi;
   logic [31:0]                       rsp_pressure_pascal;
   logic [esc_pkg::HumOutWidth-1:0]   rsp_humidity_q10;
   logic signed [31:0]                rsp_fine_temperature;
   logic                              csr_write;
   logic [esc_pkg::CsrIndexWidth-1:0] csr_index;
   logic [esc_pkg::CsrDataWidth-1:0]  csr_wdata;
   int                                error_count;
   int                                pending_count;
   int                                checked_count;
   int                                cycle_count = 0;
   int                                sent_count;

   env_sensor_compensation_core dut (.*);

   esc_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The receiver stalls in runs whose density changes from phase to phase.
   int stall_mode;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   task automatic write_trim(esc_pkg::csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_trims(logic [63:0] tt, logic [63:0] pa, logic [63:0] pb,
                             logic [63:0] pc, logic [63:0] ht);
      write_trim(esc_pkg::CSR_TEMP_TRIM, tt);
      write_trim(esc_pkg::CSR_PRESS_TRIM_A, pa);
      write_trim(esc_pkg::CSR_PRESS_TRIM_B, pb);
      write_trim(esc_pkg::CSR_PRESS_TRIM_C, pc);
      write_trim(esc_pkg::CSR_HUM_TRIM, ht);
   endtask

   // Presents one sample word at a falling edge and holds it until accepted.
   task automatic send_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
      req_valid <= 1'b1;
      req_raw_temperature <= rt;
      req_raw_pressure <= rp;
      req_raw_humidity <= rh;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (Latency + 10) @(negedge clock);
   endtask

   task automatic random_burst_run(int items);
      int n;
      int burst;
      n = 0;
      while (n < items) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && n < items) begin
            if ($urandom_range(0, 3) == 0) begin
               send_sample(20'($urandom), 20'($urandom), 16'($urandom));
            end else begin
               send_sample(20'($urandom_range(300000, 700000)),
                           20'($urandom_range(200000, 500000)),
                           16'($urandom_range(20000, 40000)));
            end
            burst--;
            n++;
         end
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   endtask

   task automatic directed_run;
      send_sample(20'h00000, 20'h00000, 16'h0000);
      send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
      send_sample(20'h55555, 20'hAAAAA, 16'h5555);
      send_sample(20'd519888, 20'd415148, 16'd27000);
      send_sample(20'd400000, 20'd300000, 16'd0);
      send_sample(20'd600000, 20'd100000, 16'hFFFF);
      send_sample(20'h80000, 20'h80000, 16'h8000);
   endtask

   logic [63:0] typ_tt, typ_pa, typ_pb, typ_pc, typ_ht;

   initial begin
      int phase;
      sent_count = 0;
      stall_mode = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_raw_temperature = '0;
      req_raw_pressure = '0;
      req_raw_humidity = '0;
      csr_write = 1'b0;
      csr_index = esc_pkg::CSR_TEMP_TRIM;
      csr_wdata = '0;
      // Typical factory coefficients so that most samples land in range.
      typ_tt = 64'({16'd50, 16'd26435, 16'd27504});
      typ_pa = 64'({16'hEFF9, 16'hD67E, 16'd36477});
      typ_pb = 64'({16'hFFF9, 16'd140, 16'd2855});
      typ_pc = 64'({16'd6000, 16'hC5FC, 16'd15500});
      typ_ht = {8'd30, 12'd0, 12'd331, 8'd0, 16'd360, 8'd75};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset trims give a zero pressure divisor everywhere.
      directed_run();
      drain();

      for (phase = 0; phase < 6; phase++) begin
         stall_mode = phase % 3;
         case (phase)
            0: load_trims(typ_tt, typ_pa, typ_pb, typ_pc, typ_ht);
            1: load_trims('1, '1, '1, '1, '1);
            2: load_trims(typ_tt, typ_pa, typ_pb, typ_pc, typ_ht);
            3: load_trims({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom});
            4: load_trims(64'({16'h7FFF, 16'h8000, 16'hFFFF}),
                          64'({16'h8000, 16'h7FFF, 16'hFFFF}),
                          64'({16'h7FFF, 16'h8000, 16'h7FFF}),
                          64'({16'h8000, 16'h7FFF, 16'h8000}),
                          {8'h80, 12'h7FF, 12'h800, 8'hFF, 16'h8000, 8'hFF});
            default: load_trims(typ_tt ^ {$urandom, $urandom}, typ_pa, typ_pb, typ_pc,
                                typ_ht ^ {$urandom, $urandom});
         endcase
         directed_run();
         random_burst_run((phase == 0 || phase == 2 || phase == 5) ? 450 : 150);
         drain();
      end

      $display("Sent %0d sample words over seven trim settings; %0d results checked.",
               sent_count, checked_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
